>>> rtl/adcs_pkg.sv
`default_nettype none

package adcs_pkg;

  // Field and register widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int DZ_W             = 15;
  localparam int GAIN_W           = 16;
  localparam int OUT_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  // Internal number formats
  localparam int Q_W       = 32;              // magnitude in Q.31
  localparam int T_FRAC    = 24;              // travel t in unsigned Q1.24
  localparam int T_W       = T_FRAC + 1;
  localparam int DIV_STEPS = T_W;             // one quotient bit per stage
  localparam int DZ_SHIFT  = Q_W - 1 - DZ_W;  // deadzone Q0.15 -> Q.31

  localparam logic [Q_W:0]  ONE_Q31   = (Q_W + 1)'(1) << (Q_W - 1);
  localparam logic [Q_W-1:0] DIV_ONE  = Q_W'(1) << (Q_W - 1);
  localparam logic [T_W+GAIN_W-1:0] ROUND_HALF = (T_W + GAIN_W)'(1) << (T_FRAC - 1);

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;
  localparam logic [OUT_W-1:0]         OUT_MAX    = {1'b0, {(OUT_W - 1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADZONE      = 3'd0,
    CFG_CURVE_CUBIC   = 3'd1,
    CFG_ABSOLUTE_MODE = 3'd2,
    CFG_INVERT_AXIS   = 3'd3,
    CFG_GAIN          = 3'd4
  } cfg_idx_e;

  // Divider stage payload
  typedef struct packed {
    logic [Q_W-1:0] rem;
    logic [T_W-1:0] quo;
    logic [T_W-1:0] t_abs;
    logic           dir_neg;
    logic           in_dz;
  } div_t;

  // One result item
  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    active;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/axis_deadzone_curve_shaper_core.sv
`default_nettype none

// Channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------------
// input     | in        | in_valid_i / in_stall_o   | raw_sample_i (Q1.x signed)
// output    | out       | out_valid_o / out_stall_i | shaped_value_o (Q4.12), active_o
// config    | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Throughput: one item per cycle while in_stall_o is low. Pipeline: input reg (loads on
// the accepting edge), 2 prep stages, 25 divider stages, 3 multiply stages, output reg.
// The 25-stage radix-2 restoring divider sets the depth.
// Reset: valid bits (pipe, output, skid) and config registers clear asynchronously; no clearing pass.
// Stalls: a stalled output parks the next item in a skid register; in_stall_o rises
// only once that skid holds an item, and the whole pipe freezes until it drains.

module axis_deadzone_curve_shaper_core #(
  parameter int SAMPLE_WIDTH = adcs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        raw_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [adcs_pkg::OUT_W-1:0]     shaped_value_o,
  output logic                                  active_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [adcs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [adcs_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import adcs_pkg::*;

  localparam int SHIFT = Q_W - SAMPLE_WIDTH;     // sample -> Q.31
  localparam int NPIPE = 3 + DIV_STEPS + 3;      // stages ahead of the output reg
  localparam int LAST  = NPIPE - 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DZ_W-1:0]          deadzone_q;
  logic                     curve_cubic_q;
  logic                     absolute_mode_q;
  logic                     invert_axis_q;
  logic signed [GAIN_W-1:0] gain_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q      <= '0;
      curve_cubic_q   <= 1'b0;
      absolute_mode_q <= 1'b0;
      invert_axis_q   <= 1'b0;
      gain_q          <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEADZONE:      deadzone_q      <= cfg_data_i[DZ_W-1:0];
        CFG_CURVE_CUBIC:   curve_cubic_q   <= cfg_data_i[0];
        CFG_ABSOLUTE_MODE: absolute_mode_q <= cfg_data_i[0];
        CFG_INVERT_AXIS:   invert_axis_q   <= cfg_data_i[0];
        CFG_GAIN:          gain_q          <= signed'(cfg_data_i[GAIN_W-1:0]);
        default: ;  // unused index, ignored
      endcase
    end
  end

  // Deadzone and divisor in Q.31; user must keep them stable while items are in flight, not enforced.
  logic [Q_W-1:0] dz_q31;
  logic [Q_W-1:0] divisor;

  assign dz_q31  = {1'b0, deadzone_q, {DZ_SHIFT{1'b0}}};
  assign divisor = DIV_ONE - dz_q31;   // never below 2^16

  // ---------------------------------------------------------------------------
  // Pipe control: global enable, held off only while the skid is full
  // ---------------------------------------------------------------------------
  logic             skid_v_q;
  logic             en;
  logic [NPIPE-1:0] vld_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NPIPE-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] s0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= raw_sample_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: scale to Q.31, magnitude, optionally inverted copy for absolute mode
  // ---------------------------------------------------------------------------
  logic signed [Q_W:0] x1;
  logic signed [Q_W:0] nx1;
  logic [Q_W-1:0]      mag1_q;
  logic                neg1_q;
  logic signed [Q_W:0] r1_q;

  assign x1  = (Q_W + 1)'(s0_q) <<< SHIFT;
  assign nx1 = -x1;   // most negative sample becomes exactly +1.0

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q <= s0_q[SAMPLE_WIDTH-1] ? nx1[Q_W-1:0] : x1[Q_W-1:0];
      neg1_q <= s0_q[SAMPLE_WIDTH-1];
      r1_q   <= invert_axis_q ? nx1 : x1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: deadzone test, excess, absolute-mode travel
  // ---------------------------------------------------------------------------
  logic [Q_W:0]   u2;
  logic           in_dz2;
  logic [Q_W-1:0] excess2;
  div_t           p2_d;
  div_t           p2_q;

  always_comb begin
    u2      = unsigned'(r1_q) + ONE_Q31;   // [0, 2^32]
    in_dz2  = (mag1_q <= dz_q31);
    excess2 = mag1_q - dz_q31;

    p2_d.rem     = (in_dz2 || absolute_mode_q) ? '0 : excess2;
    p2_d.quo     = '0;
    p2_d.t_abs   = u2[Q_W:Q_W-T_W+1];
    p2_d.dir_neg = !absolute_mode_q && (neg1_q ^ invert_axis_q);
    p2_d.in_dz   = !absolute_mode_q && in_dz2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= p2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3..27: restoring divider, one quotient bit per stage.
  // The excess never exceeds the divisor, so the quotient fits Q1.24 and the
  // first step (weight 1.0) does not shift.
  // ---------------------------------------------------------------------------
  div_t div_in [DIV_STEPS];
  div_t div_q  [DIV_STEPS];

  assign div_in[0] = p2_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [Q_W:0] r2;
    logic [Q_W:0] diff;
    logic         ge;
    div_t         nxt;

    if (i > 0) begin : g_link
      assign div_in[i] = div_q[i-1];
    end

    always_comb begin
      r2   = (i == 0) ? {1'b0, div_in[i].rem} : {div_in[i].rem, 1'b0};
      diff = r2 - {1'b0, divisor};
      ge   = (r2 >= {1'b0, divisor});
      nxt      = div_in[i];
      nxt.rem  = ge ? diff[Q_W-1:0] : r2[Q_W-1:0];
      nxt.quo  = {div_in[i].quo[T_W-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C1: pick travel, square it
  // ---------------------------------------------------------------------------
  div_t             dq;
  logic [T_W-1:0]   t_sel;
  logic [2*T_W-1:0] sq;
  logic [T_W-1:0]   c1_t_q;
  logic [T_W-1:0]   c1_t2_q;
  logic             c1_neg_q;
  logic             c1_dz_q;

  assign dq    = div_q[DIV_STEPS-1];
  assign t_sel = absolute_mode_q ? dq.t_abs : dq.quo;
  assign sq    = (2 * T_W)'(t_sel) * (2 * T_W)'(t_sel);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_t_q   <= t_sel;
      c1_t2_q  <= sq[T_FRAC+T_W-1:T_FRAC];
      c1_neg_q <= dq.dir_neg;
      c1_dz_q  <= dq.in_dz;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C2: cube, curve select (absolute mode is always linear)
  // ---------------------------------------------------------------------------
  logic [2*T_W-1:0] cu;
  logic [T_W-1:0]   c2_t_q;
  logic             c2_neg_q;
  logic             c2_dz_q;

  assign cu = (2 * T_W)'(c1_t2_q) * (2 * T_W)'(c1_t_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_t_q   <= (curve_cubic_q && !absolute_mode_q) ? cu[T_FRAC+T_W-1:T_FRAC] : c1_t_q;
      c2_neg_q <= c1_neg_q;
      c2_dz_q  <= c1_dz_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C3: multiply by |gain|; a negative gain flips the direction
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]        gain_abs;
  logic [T_W+GAIN_W-1:0]    c3_prod_q;
  logic                     c3_neg_q;
  logic                     c3_dz_q;

  assign gain_abs = gain_q[GAIN_W-1] ? unsigned'(-gain_q) : unsigned'(gain_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_prod_q <= (T_W + GAIN_W)'(c2_t_q) * (T_W + GAIN_W)'(gain_abs);
      c3_neg_q  <= c2_neg_q ^ gain_q[GAIN_W-1];
      c3_dz_q   <= c2_dz_q;
    end
  end

  // Round half away from zero, apply sign, saturate. Magnitude tops at 2^15,
  // so only the positive side can overflow.
  logic [T_W+GAIN_W-1:0] rsum;
  logic [OUT_W:0]        rmag;
  logic [OUT_W:0]        rneg;
  res_t                  res;

  always_comb begin
    rsum = c3_prod_q + ROUND_HALF;
    rmag = rsum[T_FRAC+OUT_W:T_FRAC];
    rneg = -rmag;
    if (c3_dz_q) begin
      res.value = '0;
    end else if (c3_neg_q) begin
      res.value = signed'(rneg[OUT_W-1:0]);
    end else if (rmag[OUT_W] || rmag[OUT_W-1]) begin
      res.value = signed'(OUT_MAX);
    end else begin
      res.value = signed'(rmag[OUT_W-1:0]);
    end
    res.active = !c3_dz_q;
  end

  // ---------------------------------------------------------------------------
  // Output register with skid
  // ---------------------------------------------------------------------------
  logic ov_q;
  logic o_free;
  res_t out_q;
  res_t skid_q;

  assign o_free = !ov_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q     <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (o_free) begin
        ov_q     <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (vld_q[LAST]) begin
      if (o_free) begin
        ov_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (o_free) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (o_free) begin
        out_q <= skid_q;
      end
    end else if (vld_q[LAST]) begin
      if (o_free) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign shaped_value_o = out_q.value;
  assign active_o       = out_q.active;

endmodule

`default_nettype wire

>>> rtl/adcs_checker.sv
`default_nettype none

module adcs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [adcs_pkg::OUT_W-1:0] shaped_value_o,
  input logic                              active_o
);
  import adcs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shaped_value_o) && $stable(active_o))
    else $error("stalled result changed");

  // an inactive result is zero
  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_o |-> shaped_value_o == '0)
    else $error("inactive result not zero");

  // input backpressure only while a result waits
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // skid fills only after the output was stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_stall_i))
    else $error("input stall without output stall");

endmodule

bind axis_deadzone_curve_shaper_core adcs_checker u_adcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .shaped_value_o (shaped_value_o),
  .active_o       (active_o)
);

`default_nettype wire
